// ===== sv/zbdt_pkg.sv =====
// shared constants and types for the z-buffer depth test block
// no dependencies; compiled first
`default_nettype none

package zbdt_pkg;

  // fixed field widths of the point and result channels
  localparam int CoordW   = 9;
  localparam int DepthInW = 24;
  localparam int ColorW   = 8;

  // default screen geometry and depth precision
  localparam int ScreenWidthDef  = 512;
  localparam int ScreenHeightDef = 512;
  localparam int DepthBitsDef    = 24;

  // point as it travels down the pipeline
  typedef struct packed {
    logic [CoordW-1:0]   pixel_x;
    logic [CoordW-1:0]   pixel_y;
    logic [ColorW-1:0]   red;
    logic [ColorW-1:0]   green;
    logic [ColorW-1:0]   blue;
    logic [ColorW-1:0]   alpha;
  } pix_t;

  // result as held in the output register
  typedef struct packed {
    logic                draw;
    logic [CoordW-1:0]   out_x;
    logic [CoordW-1:0]   out_y;
    logic [ColorW-1:0]   out_red;
    logic [ColorW-1:0]   out_green;
    logic [ColorW-1:0]   out_blue;
    logic [ColorW-1:0]   out_alpha;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/zbdt_pix_if.sv =====
// point channel: valid/ready handshake with coordinate, depth and color
// depends on zbdt_pkg
`default_nettype none

interface zbdt_pix_if import zbdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CoordW-1:0]   pixel_x;
  logic [CoordW-1:0]   pixel_y;
  logic [DepthInW-1:0] depth;
  logic [ColorW-1:0]   red;
  logic [ColorW-1:0]   green;
  logic [ColorW-1:0]   blue;
  logic [ColorW-1:0]   alpha;

  modport source (output valid, pixel_x, pixel_y, depth, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, depth, red, green, blue, alpha,
                output ready);
endinterface

`default_nettype wire

// ===== sv/zbdt_res_if.sv =====
// result channel: valid/ready handshake with draw flag, coordinate and color
// depends on zbdt_pkg
`default_nettype none

interface zbdt_res_if import zbdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              draw;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic [ColorW-1:0] out_red;
  logic [ColorW-1:0] out_green;
  logic [ColorW-1:0] out_blue;
  logic [ColorW-1:0] out_alpha;

  modport source (output valid, draw, out_x, out_y, out_red, out_green, out_blue,
                  out_alpha, input ready);
  modport sink (input valid, draw, out_x, out_y, out_red, out_green, out_blue,
                out_alpha, output ready);
endinterface

`default_nettype wire

// ===== sv/zbdt_mem.sv =====
// depth store memory: one write port, one read port, registered read data
// depends on nothing but its parameters
`default_nettype none

module zbdt_mem #(
  parameter int Depth = 262144,
  parameter int AddrW = 18,
  parameter int DataW = 25
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/zbdt_clear.sv =====
// clearing sweep over the depth store after reset, one entry per cycle
// depends on nothing but its parameters
`default_nettype none

module zbdt_clear #(
  parameter int Depth = 262144,
  parameter int AddrW = 18
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  output      logic             busy_o,
  output      logic [AddrW-1:0] addr_o
);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] addr_q, addr_d;

  // step through every entry, then stop
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      if (addr_q == AddrW'(Depth - 1)) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

`default_nettype wire

// ===== sv/z_buffer_depth_test.sv =====
// a point and its store read are registered in stage 1, then the test result in
// the output register; throughput: one point per cycle while results are taken
// and no sweep runs; the depth store reads each taken point and writes back one
// that passes with the test on, the last write forwarded to the following point
// reset: a clearing sweep writes every store entry (262144 at the defaults) with
// pix_i.ready low; depth test starts on
`default_nettype none

module z_buffer_depth_test import zbdt_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef,
  parameter int DEPTH_BITS    = DepthBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  depth_test_on_we_i,
  input  wire logic  depth_test_on_i,
  zbdt_pix_if.sink   pix_i,
  zbdt_res_if.source res_o
);

  // only coordinates the fields can carry reach the store
  localparam int CoordMax = 2 ** CoordW;
  localparam int EffW     = (SCREEN_WIDTH < CoordMax) ? SCREEN_WIDTH : CoordMax;
  localparam int EffH     = (SCREEN_HEIGHT < CoordMax) ? SCREEN_HEIGHT : CoordMax;
  localparam int Depth    = EffW * EffH;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ExtW     = (DEPTH_BITS > DepthInW) ? DEPTH_BITS : DepthInW;
  localparam int WordW    = DEPTH_BITS + 1;

  // configuration register
  logic cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 1'b1;
    end else if (depth_test_on_we_i) begin
      cfg_q <= depth_test_on_i;
    end
  end

  // clearing sweep
  logic             clr_busy;
  logic [AddrW-1:0] clr_addr;

  zbdt_clear #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // stage 0: address and depth of the incoming point
  logic                  pix_xfer;
  logic                  s0_inrange;
  logic [AddrW-1:0]      s0_addr;
  logic [ExtW-1:0]       s0_zext;
  logic                  s1_adv;
  logic                  s1_valid_q, s1_valid_d;

  assign pix_i.ready = !clr_busy && (!s1_valid_q || s1_adv);
  assign pix_xfer    = pix_i.valid && pix_i.ready;
  assign s0_inrange  = (int'(pix_i.pixel_x) < SCREEN_WIDTH) &&
                       (int'(pix_i.pixel_y) < SCREEN_HEIGHT);
  assign s0_addr     = AddrW'(int'(pix_i.pixel_y) * EffW + int'(pix_i.pixel_x));
  assign s0_zext     = ExtW'(pix_i.depth);

  // stage 1 registers
  pix_t                  s1_pix_q;
  logic                  s1_inrange_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic [DEPTH_BITS-1:0] s1_z_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_pix_q     <= '{pixel_x: pix_i.pixel_x, pixel_y: pix_i.pixel_y,
                        red: pix_i.red, green: pix_i.green,
                        blue: pix_i.blue, alpha: pix_i.alpha};
      s1_inrange_q <= s0_inrange;
      s1_addr_q    <= s0_addr;
      s1_z_q       <= s0_zext[DEPTH_BITS-1:0];
    end
  end

  // depth store, word is valid mark over depth
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;

  zbdt_mem #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (WordW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (pix_xfer),
    .raddr_i (s0_addr),
    .rdata_o (mem_rdata)
  );

  // last write, forwarded to a point whose read raced it
  logic             fwd_en_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [WordW-1:0] fwd_data_q;

  // stage 1: depth test against stored or forwarded entry
  logic             s1_hit;
  logic [WordW-1:0] s1_cur;
  logic             s1_pass;
  logic             s1_wr;

  assign s1_hit  = fwd_en_q && (fwd_addr_q == s1_addr_q);
  assign s1_cur  = s1_hit ? fwd_data_q : mem_rdata;
  assign s1_pass = !cfg_q ||
                   (s1_inrange_q && !(s1_cur[DEPTH_BITS] &&
                                      (s1_cur[DEPTH_BITS-1:0] < s1_z_q)));
  assign s1_wr   = s1_valid_q && s1_adv && cfg_q && s1_pass;

  // store write mux: sweep first, then depth updates
  always_comb begin
    mem_we    = s1_wr;
    mem_waddr = s1_addr_q;
    mem_wdata = {1'b1, s1_z_q};
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q <= 1'b0;
    end else if (s1_wr) begin
      fwd_en_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= {1'b1, s1_z_q};
    end
  end

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;

  assign s1_adv = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    out_d = '0;
    if (s1_pass) begin
      out_d = '{draw: 1'b1, out_x: s1_pix_q.pixel_x, out_y: s1_pix_q.pixel_y,
                out_red: s1_pix_q.red, out_green: s1_pix_q.green,
                out_blue: s1_pix_q.blue, out_alpha: s1_pix_q.alpha};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.draw      = out_q.draw;
  assign res_o.out_x     = out_q.out_x;
  assign res_o.out_y     = out_q.out_y;
  assign res_o.out_red   = out_q.out_red;
  assign res_o.out_green = out_q.out_green;
  assign res_o.out_blue  = out_q.out_blue;
  assign res_o.out_alpha = out_q.out_alpha;

`ifndef SYNTHESIS
  // no point is taken while the sweep owns the store
  a_no_xfer_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer |-> !clr_busy)
    else $error("point transfer during clearing sweep");

  // a depth update only for an on-screen point with the test enabled
  a_write_qualified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_wr |-> (cfg_q && s1_inrange_q && !clr_busy))
    else $error("depth write without enabled test or on-screen point");

  // a hidden point carries no coordinate and no color
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.draw) |->
      (res_o.out_x == '0 && res_o.out_y == '0 && res_o.out_red == '0 &&
       res_o.out_green == '0 && res_o.out_blue == '0 && res_o.out_alpha == '0))
    else $error("hidden point with nonzero fields");
`endif

endmodule

`default_nettype wire
